>>> sv/qqt_pkg.sv
`timescale 1ns / 1ps

package qqt_pkg;

  localparam int unsigned IDX_W    = 7;
  localparam int unsigned QUAL_W   = 8;
  localparam int unsigned VAL_W    = 8;
  localparam int unsigned BASE_W   = 7;
  localparam int unsigned SCALE_W  = 13;
  localparam int unsigned PROD_W   = 20;
  localparam int unsigned LOW_W    = 15;
  localparam int unsigned RCP_W    = 13;
  localparam int unsigned QUO_W    = LOW_W + RCP_W;
  localparam int unsigned RCP_SH   = 19;

  localparam logic [QUAL_W-1:0]  QUAL_RESET  = 8'd50;
  localparam logic [QUAL_W-1:0]  QUAL_MID    = 8'd50;
  localparam logic [QUAL_W-1:0]  QUAL_MAX    = 8'd100;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 13'd100;
  localparam logic [PROD_W-1:0]  ROUND_ADD   = 20'd50;
  // smallest product+rounding whose quotient by 100 exceeds 255
  localparam logic [PROD_W-1:0]  SAT_LIMIT   = 20'd25600;
  // ceil(2^19 / 100); exact for products below SAT_LIMIT
  localparam logic [RCP_W-1:0]   RCP_100     = 13'd5243;
  localparam logic [VAL_W-1:0]   VAL_MAX     = 8'd255;
  localparam logic [VAL_W-1:0]   VAL_MIN     = 8'd1;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [VAL_W-1:0]   val_t;
  typedef logic [QUAL_W-1:0]  qual_t;
  typedef logic [SCALE_W-1:0] scale_t;
  typedef logic [BASE_W-1:0]  base_t;

  // luma entries 0..63, chroma entries 64..127
  localparam base_t BASE_TAB [128] = '{
    7'd16, 7'd11, 7'd10, 7'd16, 7'd24, 7'd40, 7'd51, 7'd61,
    7'd12, 7'd12, 7'd14, 7'd19, 7'd26, 7'd58, 7'd60, 7'd55,
    7'd14, 7'd13, 7'd16, 7'd24, 7'd40, 7'd57, 7'd69, 7'd56,
    7'd14, 7'd17, 7'd22, 7'd29, 7'd51, 7'd87, 7'd80, 7'd62,
    7'd18, 7'd22, 7'd37, 7'd56, 7'd68, 7'd109, 7'd103, 7'd77,
    7'd24, 7'd35, 7'd55, 7'd64, 7'd81, 7'd104, 7'd113, 7'd92,
    7'd49, 7'd64, 7'd78, 7'd87, 7'd103, 7'd121, 7'd120, 7'd101,
    7'd72, 7'd92, 7'd95, 7'd98, 7'd112, 7'd100, 7'd103, 7'd99,
    7'd17, 7'd18, 7'd24, 7'd47, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd18, 7'd21, 7'd26, 7'd66, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd24, 7'd26, 7'd56, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd47, 7'd66, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99
  };

  // 5000 / q for q = 1..50; quality zero reads entry 0 as quality one
  localparam scale_t LOW_SCALE_TAB [64] = '{
    13'd5000, 13'd5000, 13'd2500, 13'd1666, 13'd1250, 13'd1000, 13'd833, 13'd714,
    13'd625,  13'd555,  13'd500,  13'd454,  13'd416,  13'd384,  13'd357, 13'd333,
    13'd312,  13'd294,  13'd277,  13'd263,  13'd250,  13'd238,  13'd227, 13'd217,
    13'd208,  13'd200,  13'd192,  13'd185,  13'd178,  13'd172,  13'd166, 13'd161,
    13'd156,  13'd151,  13'd147,  13'd142,  13'd138,  13'd135,  13'd131, 13'd128,
    13'd125,  13'd121,  13'd119,  13'd116,  13'd113,  13'd111,  13'd108, 13'd106,
    13'd104,  13'd102,  13'd100,  13'd100,  13'd100,  13'd100,  13'd100, 13'd100,
    13'd100,  13'd100,  13'd100,  13'd100,  13'd100,  13'd100,  13'd100, 13'd100
  };

  // Clamp quality to 1..100 and map it to the scale factor
  function automatic scale_t scale_of(input qual_t q);
    logic [QUAL_W-1:0] lin;
    scale_t            s;
    lin = 8'd200 - {q[QUAL_W-2:0], 1'b0};
    if (q > QUAL_MAX) begin
      s = '0;
    end else if (q > QUAL_MID) begin
      s = {{(SCALE_W-QUAL_W){1'b0}}, lin};
    end else begin
      s = LOW_SCALE_TAB[q[5:0]];
    end
    return s;
  endfunction

endpackage

>>> sv/qqt_in_if.sv
`timescale 1ns / 1ps

interface qqt_in_if;
  logic          valid;
  logic          ready;
  qqt_pkg::idx_t entry_index;

  modport source (output valid, output entry_index, input ready);
  modport sink   (input valid, input entry_index, output ready);
endinterface

>>> sv/qqt_out_if.sv
`timescale 1ns / 1ps

interface qqt_out_if;
  logic          valid;
  logic          ready;
  qqt_pkg::idx_t entry_out;
  qqt_pkg::val_t quant_value;

  modport source (output valid, output entry_out, output quant_value, input ready);
  modport sink   (input valid, input entry_out, input quant_value, output ready);
endinterface

>>> sv/qqt_scale.sv
`timescale 1ns / 1ps

module qqt_scale (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  qqt_pkg::qual_t   cfg_data,
  output qqt_pkg::scale_t  scale
);

  // Store the scale factor in the same edge as the quality write
  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= qqt_pkg::SCALE_RESET;
    end else if (cfg_we) begin
      scale <= qqt_pkg::scale_of(cfg_data);
    end
  end

endmodule

>>> sv/qqt_datapath.sv
`timescale 1ns / 1ps

module qqt_datapath (
  input  logic            clk,
  input  logic            rst,
  input  qqt_pkg::scale_t scale,
  qqt_in_if.sink          entry,
  qqt_out_if.source       result
);

  // stage valids
  logic s1_valid, s2_valid, s3_valid, s4_valid;
  logic s1_ready, s2_ready, s3_ready, s4_ready;

  // stage payloads
  qqt_pkg::idx_t                  s1_index, s2_index, s3_index, s4_index;
  qqt_pkg::base_t                 s1_base;
  qqt_pkg::scale_t                s1_scale;
  logic [qqt_pkg::PROD_W-1:0]     s2_prod;
  logic                           s3_sat;
  logic [qqt_pkg::QUO_W-1:0]      s3_quo;
  qqt_pkg::val_t                  s4_value;
  qqt_pkg::val_t                  s4_value_next;
  logic [qqt_pkg::PROD_W-1:0]     prod_next;
  logic [qqt_pkg::QUO_W-1:0]      quo_next;

  // Each stage takes a request when empty or when its successor moves
  assign s4_ready = !s4_valid || result.ready;
  assign s3_ready = !s3_valid || s4_ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign entry.ready = s1_ready;

  // Stage 1: look up the base entry, capture the scale
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= entry.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && entry.valid) begin
      s1_index <= entry.entry_index;
      s1_base  <= qqt_pkg::BASE_TAB[entry.entry_index];
      s1_scale <= scale;
    end
  end

  // Stage 2: base * scale plus rounding, at full product width
  assign prod_next = qqt_pkg::PROD_W'(s1_base) * qqt_pkg::PROD_W'(s1_scale)
                     + qqt_pkg::ROUND_ADD;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_index <= s1_index;
      s2_prod  <= prod_next;
    end
  end

  // Stage 3: flag saturation, multiply the low part by the reciprocal of 100
  assign quo_next = s2_prod[qqt_pkg::LOW_W-1:0] * qqt_pkg::RCP_100;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_ready) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s2_valid) begin
      s3_index <= s2_index;
      s3_sat   <= (s2_prod >= qqt_pkg::SAT_LIMIT);
      s3_quo   <= quo_next;
    end
  end

  // Stage 4: take the quotient, clamp to 1..255
  always_comb begin
    if (s3_sat) begin
      s4_value_next = qqt_pkg::VAL_MAX;
    end else if (s3_quo[qqt_pkg::RCP_SH +: qqt_pkg::VAL_W] == '0) begin
      s4_value_next = qqt_pkg::VAL_MIN;
    end else begin
      s4_value_next = s3_quo[qqt_pkg::RCP_SH +: qqt_pkg::VAL_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (s4_ready) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_ready && s3_valid) begin
      s4_index <= s3_index;
      s4_value <= s4_value_next;
    end
  end

  assign result.valid       = s4_valid;
  assign result.entry_out   = s4_index;
  assign result.quant_value = s4_value;

  // Checks
  a_value_nonzero: assert property (@(posedge clk) disable iff (rst)
    s4_valid |-> s4_value != '0)
    else $error("result value is zero");

  a_sat_to_max: assert property (@(posedge clk) disable iff (rst)
    (s3_valid && s3_sat && s4_ready) |=> s4_value == qqt_pkg::VAL_MAX)
    else $error("saturated request did not give the maximum value");

  a_prod_floor: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> s2_prod >= qqt_pkg::ROUND_ADD)
    else $error("product lost its rounding term");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s2_ready) |=> (s1_valid && $stable(s1_index) && $stable(s1_base)))
    else $error("stage 1 request changed while stalled");

endmodule

>>> sv/jpeg_quality_quant_table_gen_unit.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake     Payload
// entry     in   valid/ready   entry_index [6:0]
// result    out  valid/ready   entry_out [6:0], quant_value [7:0]
// cfg       in   cfg_we        cfg_data [7:0] (quality)
//
// Four register stages: table lookup, multiply-add, reciprocal multiply,
// clamp into the output register. One request per cycle while result is not stalled.
// Synchronous reset clears stage valids and sets the scale to that of quality 50.
// A stall on result backs up stage by stage; empty stages still fill.
// The scale is derived at the quality write, so write only while idle.

module jpeg_quality_quant_table_gen_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  qqt_pkg::qual_t cfg_data,
  qqt_in_if.sink         entry,
  qqt_out_if.source      result
);

  qqt_pkg::scale_t scale;

  qqt_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .scale    (scale)
  );

  qqt_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .scale  (scale),
    .entry  (entry),
    .result (result)
  );

endmodule
